FILE: rtl/assert_macros.svh
// Assertion macros used by sliding_window_trimmed_mean.
// Each macro takes a label, a clock and a reset, then a property expression or its antecedent and consequent.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Invariant checked on every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

`endif

FILE: rtl/swtm_pkg.sv
// Package for the sliding window trimmed mean block.
// Holds the state machine type and the register indexes; no dependencies.
package swtm_pkg;

    localparam int unsigned CfgIdxBits = 1;
    localparam logic [CfgIdxBits-1:0] REG_WINDOW_LEN = 1'b0;
    localparam logic [CfgIdxBits-1:0] REG_TRIM_COUNT = 1'b1;
    localparam int unsigned CfgDataBits = 7;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WRITE,
        ST_GATHER_RD,
        ST_GATHER_WT,
        ST_INSERT,
        ST_SUM_RD,
        ST_SUM_WT,
        ST_DIVIDE,
        ST_OUTPUT
    } state_t;

endpackage

FILE: rtl/swtm_stream_if.sv
// Valid/ready channel interface carrying a payload of parameterized width.
// Depends on nothing.
interface swtm_stream_if #(
    parameter int unsigned WIDTH = 17
);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/swtm_ram.sv
// Generic single-port write, single-port read RAM with registered read data.
// Depends on nothing.
module swtm_ram #(
    parameter int unsigned WIDTH = 17,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: rtl/sliding_window_trimmed_mean.sv
// Sliding window trimmed mean.
// Channels: in_ch carries one sample per transaction; out_ch carries
// {ready_res, trimmed_mean} per transaction, one result for each sample.
// Configuration: cfg_we, cfg_idx, cfg_data; index 0 is window_len and
// index 1 is trim_count. Write only while the block is idle.
// A sample is written into the arrival ring. When the window is full and
// the trim is valid, the last w samples are read one by one and placed by
// insertion into the sorted memory (one read, compare and shift per cycle),
// then the middle samples are summed one read at a time, then a restoring
// divider produces one quotient bit per cycle.
// A result that is not ready goes from the write state straight to output.
// One sample is in flight at a time; in_ch.ready is high only when idle,
// so the next sample can be taken in the cycle after the result is delivered.
// Reset clears the pointer, fill count and control state; memory contents
// are not cleared. If out_ch stalls, the result is held in the output
// register and no new sample is taken until it is delivered.
module sliding_window_trimmed_mean #(
    parameter int unsigned MAX_WINDOW  = 64,
    parameter int unsigned SAMPLE_BITS = 17
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [swtm_pkg::CfgIdxBits-1:0]     cfg_idx,
    input  logic [swtm_pkg::CfgDataBits-1:0]    cfg_data,
    swtm_stream_if.sink                         in_ch,
    swtm_stream_if.source                       out_ch
);
    `include "assert_macros.svh"

    localparam int unsigned AW       = $clog2(MAX_WINDOW);
    localparam int unsigned CW       = $clog2(MAX_WINDOW + 1);
    localparam int unsigned SUM_BITS = SAMPLE_BITS + CW;

    swtm_pkg::state_t state_reg, state_next;

    logic [6:0]             window_len_reg;
    logic [4:0]             trim_count_reg;
    logic [AW-1:0]          ptr_reg, ptr_next;
    logic [CW-1:0]          fill_reg, fill_next;
    logic [CW-1:0]          w_reg, w_next;
    logic [CW-1:0]          i_reg, i_next;
    logic [CW-1:0]          j_reg, j_next;
    logic [SAMPLE_BITS-1:0] v_reg, v_next;
    logic [SUM_BITS-1:0]    sum_reg, sum_next;
    logic [SUM_BITS-1:0]    rem_reg, rem_next;
    logic [SUM_BITS-1:0]    quo_reg, quo_next;
    logic [CW-1:0]          div_reg, div_next;
    logic [$clog2(SUM_BITS+1)-1:0] bit_reg, bit_next;
    logic [SAMPLE_BITS-1:0] res_reg, res_next;
    logic                   rdy_reg, rdy_next;

    // Arrival ring ports.
    logic                   ar_we;
    logic [AW-1:0]          ar_waddr, ar_raddr;
    logic [SAMPLE_BITS-1:0] ar_wdata, ar_rdata;
    // Sorted window ports.
    logic                   sw_we;
    logic [AW-1:0]          sw_waddr, sw_raddr;
    logic [SAMPLE_BITS-1:0] sw_wdata, sw_rdata;

    swtm_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_WINDOW)) u_ring (
        .clk(clk), .we(ar_we), .waddr(ar_waddr), .wdata(ar_wdata),
        .raddr(ar_raddr), .rdata(ar_rdata)
    );

    swtm_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_WINDOW)) u_sorted (
        .clk(clk), .we(sw_we), .waddr(sw_waddr), .wdata(sw_wdata),
        .raddr(sw_raddr), .rdata(sw_rdata)
    );

    logic [CW-1:0]       w_sat;
    logic [CW-1:0]       t_ext;
    logic [CW:0]         g_idx;
    logic [SUM_BITS:0]   rem_trial;

    always_comb
    begin
        if (32'(window_len_reg) > MAX_WINDOW)
        begin
            w_sat = CW'(MAX_WINDOW);
        end
        else
        begin
            w_sat = CW'(window_len_reg);
        end
        t_ext = CW'(trim_count_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= swtm_pkg::ST_IDLE;
            window_len_reg <= 7'd3;
            trim_count_reg <= 5'd1;
            ptr_reg        <= '0;
            fill_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ptr_reg   <= ptr_next;
            fill_reg  <= fill_next;
            if (cfg_we)
            begin
                case (cfg_idx)
                    swtm_pkg::REG_WINDOW_LEN: window_len_reg <= cfg_data[6:0];
                    swtm_pkg::REG_TRIM_COUNT: trim_count_reg <= cfg_data[4:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg   <= w_next;
        i_reg   <= i_next;
        j_reg   <= j_next;
        v_reg   <= v_next;
        sum_reg <= sum_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
        bit_reg <= bit_next;
        res_reg <= res_next;
        rdy_reg <= rdy_next;
    end

    always_comb
    begin
        state_next = state_reg;
        ptr_next   = ptr_reg;
        fill_next  = fill_reg;
        w_next     = w_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        v_next     = v_reg;
        sum_next   = sum_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        div_next   = div_reg;
        bit_next   = bit_reg;
        res_next   = res_reg;
        rdy_next   = rdy_reg;
        ar_we      = 1'b0;
        ar_waddr   = ptr_reg;
        ar_wdata   = in_ch.data;
        ar_raddr   = '0;
        sw_we      = 1'b0;
        sw_waddr   = '0;
        sw_wdata   = v_reg;
        sw_raddr   = '0;
        in_ch.ready  = 1'b0;
        out_ch.valid = 1'b0;
        g_idx        = '0;
        rem_trial    = '0;

        case (state_reg)
            swtm_pkg::ST_IDLE:
            begin
                in_ch.ready = 1'b1;
                if (in_ch.valid)
                begin
                    ar_we    = 1'b1;
                    ptr_next = (ptr_reg == AW'(MAX_WINDOW - 1)) ? '0 : ptr_reg + AW'(1);
                    if (fill_reg < CW'(MAX_WINDOW))
                    begin
                        fill_next = fill_reg + CW'(1);
                    end
                    w_next     = w_sat;
                    state_next = swtm_pkg::ST_WRITE;
                end
            end
            swtm_pkg::ST_WRITE:
            begin
                i_next = '0;
                if (fill_reg < w_reg || (32'(trim_count_reg) << 1) >= 32'(w_reg))
                begin
                    res_next   = '0;
                    rdy_next   = 1'b0;
                    state_next = swtm_pkg::ST_OUTPUT;
                end
                else
                begin
                    state_next = swtm_pkg::ST_GATHER_RD;
                end
            end
            swtm_pkg::ST_GATHER_RD:
            begin
                // Sample i back from the newest: ptr - 1 - i modulo the depth.
                g_idx = (CW+1)'(ptr_reg) + (CW+1)'(MAX_WINDOW - 1) - (CW+1)'(i_reg);
                if (g_idx >= (CW+1)'(MAX_WINDOW))
                begin
                    ar_raddr = AW'(g_idx - (CW+1)'(MAX_WINDOW));
                end
                else
                begin
                    ar_raddr = AW'(g_idx);
                end
                state_next = swtm_pkg::ST_GATHER_WT;
            end
            swtm_pkg::ST_GATHER_WT:
            begin
                v_next = ar_rdata;
                j_next = i_reg;
                if (i_reg != '0)
                begin
                    sw_raddr = AW'(i_reg - CW'(1));
                end
                state_next = swtm_pkg::ST_INSERT;
            end
            swtm_pkg::ST_INSERT:
            begin
                // sw_rdata holds sorted[j-1]; shift it up or place v at j.
                sw_we = 1'b1;
                sw_waddr = AW'(j_reg);
                if (j_reg != '0 && sw_rdata > v_reg)
                begin
                    sw_wdata = sw_rdata;
                    j_next   = j_reg - CW'(1);
                    if (j_reg > CW'(1))
                    begin
                        sw_raddr = AW'(j_reg - CW'(2));
                    end
                end
                else
                begin
                    sw_wdata = v_reg;
                    i_next   = i_reg + CW'(1);
                    if (i_reg + CW'(1) == w_reg)
                    begin
                        i_next     = t_ext;
                        sum_next   = '0;
                        state_next = swtm_pkg::ST_SUM_RD;
                    end
                    else
                    begin
                        state_next = swtm_pkg::ST_GATHER_RD;
                    end
                end
            end
            swtm_pkg::ST_SUM_RD:
            begin
                sw_raddr   = AW'(i_reg);
                state_next = swtm_pkg::ST_SUM_WT;
            end
            swtm_pkg::ST_SUM_WT:
            begin
                sum_next = sum_reg + SUM_BITS'(sw_rdata);
                i_next   = i_reg + CW'(1);
                if (i_reg + CW'(1) == w_reg - t_ext)
                begin
                    div_next   = w_reg - CW'({t_ext, 1'b0});
                    rem_next   = '0;
                    quo_next   = sum_reg + SUM_BITS'(sw_rdata);
                    bit_next   = '0;
                    state_next = swtm_pkg::ST_DIVIDE;
                end
                else
                begin
                    state_next = swtm_pkg::ST_SUM_RD;
                end
            end
            swtm_pkg::ST_DIVIDE:
            begin
                // Restoring division, one quotient bit per cycle.
                rem_trial = {rem_reg, quo_reg[SUM_BITS-1]} - (SUM_BITS+1)'(div_reg);
                if (!rem_trial[SUM_BITS])
                begin
                    rem_next = rem_trial[SUM_BITS-1:0];
                    quo_next = {quo_reg[SUM_BITS-2:0], 1'b1};
                end
                else
                begin
                    rem_next = {rem_reg[SUM_BITS-2:0], quo_reg[SUM_BITS-1]};
                    quo_next = {quo_reg[SUM_BITS-2:0], 1'b0};
                end
                bit_next = bit_reg + ($clog2(SUM_BITS+1))'(1);
                if (bit_reg == ($clog2(SUM_BITS+1))'(SUM_BITS - 1))
                begin
                    res_next   = quo_next[SAMPLE_BITS-1:0];
                    rdy_next   = 1'b1;
                    state_next = swtm_pkg::ST_OUTPUT;
                end
            end
            swtm_pkg::ST_OUTPUT:
            begin
                out_ch.valid = 1'b1;
                if (out_ch.ready)
                begin
                    state_next = swtm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = swtm_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_ch.data = {rdy_reg, res_reg};

    `ASSERT_IMP(a_no_accept_busy, clk, rst_n,
        state_reg != swtm_pkg::ST_IDLE, !in_ch.ready)
    `ASSERT_IMP(a_fill_bound, clk, rst_n, 1'b1, fill_reg <= CW'(MAX_WINDOW))
    `ASSERT_IMP(a_hold_stall, clk, rst_n,
        out_ch.valid && !out_ch.ready, ##1 out_ch.valid && $stable(out_ch.data))
endmodule

FILE: tb/sliding_window_trimmed_mean_test.sv
// Self-checking testbench for sliding_window_trimmed_mean.
// Depends on swtm_pkg, swtm_stream_if and the block itself; predicts each result
// from its own copy of the sample history and compares every output transaction.
module sliding_window_trimmed_mean_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned WIN_MAX   = 64;
    localparam int unsigned SMP_BITS  = 17;
    localparam int unsigned SMP_MAX   = (1 << SMP_BITS) - 1;
    localparam int unsigned ITEM_GOAL = 1150;
    localparam longint      CYCLE_CAP = 20000000;

    typedef struct packed {
        logic                rdy;
        logic [SMP_BITS-1:0] mean;
    } mean_result_t;

    logic                             clk;
    logic                             rst_n;
    logic                             cfg_we;
    logic [swtm_pkg::CfgIdxBits-1:0]  cfg_idx;
    logic [swtm_pkg::CfgDataBits-1:0] cfg_data;

    swtm_stream_if #(.WIDTH(SMP_BITS))     in_ch ();
    swtm_stream_if #(.WIDTH(SMP_BITS + 1)) out_ch ();

    sliding_window_trimmed_mean DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .in_ch    (in_ch),
        .out_ch   (out_ch)
    );

    // Predictor state.
    logic [SMP_BITS-1:0] hist_ring [WIN_MAX];
    logic [SMP_BITS-1:0] sort_buf  [WIN_MAX];
    int unsigned         hist_ptr;
    int unsigned         hist_fill;
    int unsigned         win_len_q;
    int unsigned         trim_q;

    logic [SMP_BITS-1:0] sample_queue[$];
    mean_result_t        mean_queue[$];
    int unsigned         error_count;
    int unsigned         items_sent;
    bit                  no_idle;
    longint              cycle_count;
    int unsigned         seed_vals [15];

    function automatic mean_result_t trimmed_mean_of(logic [SMP_BITS-1:0] smp);
        mean_result_t r;
        int unsigned w;
        int unsigned j;
        int unsigned total;
        logic [SMP_BITS-1:0] v;
        hist_ring[hist_ptr] = smp;
        hist_ptr = (hist_ptr + 1) % WIN_MAX;
        if (hist_fill < WIN_MAX)
            hist_fill++;
        w = (win_len_q > WIN_MAX) ? WIN_MAX : win_len_q;
        r = '0;
        if (hist_fill < w || 2 * trim_q >= w)
            return r;
        for (int unsigned i = 0; i < w; i++)
        begin
            v = hist_ring[(hist_ptr + WIN_MAX - 1 - i) % WIN_MAX];
            j = i;
            while (j > 0 && sort_buf[j-1] > v)
            begin
                sort_buf[j] = sort_buf[j-1];
                j--;
            end
            sort_buf[j] = v;
        end
        total = 0;
        for (int unsigned i = trim_q; i < w - trim_q; i++)
            total += sort_buf[i];
        r.rdy  = 1'b1;
        r.mean = SMP_BITS'(total / (w - 2 * trim_q));
        return r;
    endfunction

    function automatic logic [SMP_BITS-1:0] pick_sample();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 1) ? SMP_BITS'(0) : SMP_BITS'(SMP_MAX);
            1: return SMP_BITS'($urandom_range(0, 7));
            2: return SMP_BITS'(SMP_MAX - $urandom_range(0, 7));
            default: return SMP_BITS'($urandom);
        endcase
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Sender: one sample per transaction, with a random gap after each.
    int unsigned send_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            send_gap    <= 0;
        end
        else if (!(in_ch.valid && !in_ch.ready))
        begin
            if (in_ch.valid)
                mean_queue.push_back(trimmed_mean_of(in_ch.data));
            if (send_gap > 0)
            begin
                in_ch.valid <= 1'b0;
                send_gap    <= send_gap - 1;
            end
            else if (sample_queue.size() > 0)
            begin
                in_ch.valid <= 1'b1;
                in_ch.data  <= sample_queue.pop_front();
                send_gap    <= no_idle ? 0 : $urandom_range(0, 4);
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // Receiver: checks each result and stalls at random afterwards.
    int unsigned stall_left;
    always @(posedge clk or negedge rst_n)
    begin
        mean_result_t got;
        mean_result_t want;
        int unsigned  draw;
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            stall_left   <= 0;
        end
        else if (out_ch.valid && out_ch.ready)
        begin
            got = out_ch.data;
            if (mean_queue.size() == 0)
            begin
                $error("unexpected result: ready_res %0d trimmed_mean %0d",
                       got.rdy, got.mean);
                error_count++;
            end
            else
            begin
                want = mean_queue.pop_front();
                if (got.mean !== want.mean)
                begin
                    $error("trimmed_mean: expected %0d, got %0d", want.mean, got.mean);
                    error_count++;
                end
                if (got.rdy !== want.rdy)
                begin
                    $error("ready_res: expected %0d, got %0d", want.rdy, got.rdy);
                    error_count++;
                end
            end
            draw = no_idle ? 0 : $urandom_range(0, 4);
            stall_left   <= (draw > 0) ? draw - 1 : 0;
            out_ch.ready <= (draw == 0);
        end
        else if (stall_left > 0)
        begin
            stall_left   <= stall_left - 1;
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP)
        begin
            $display("FAIL sliding_window_trimmed_mean");
            $finish;
        end
    end

    task automatic wait_drained();
        while (sample_queue.size() > 0 || in_ch.valid || mean_queue.size() > 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_reg(logic [swtm_pkg::CfgIdxBits-1:0] idx,
                             logic [swtm_pkg::CfgDataBits-1:0] val);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    // Registers change only once the block has gone idle.
    task automatic set_window(int unsigned wl, int unsigned tc);
        wait_drained();
        write_reg(swtm_pkg::REG_WINDOW_LEN, swtm_pkg::CfgDataBits'(wl));
        write_reg(swtm_pkg::REG_TRIM_COUNT, {2'($urandom), 5'(tc)});
        win_len_q = wl & 7'h7F;
        trim_q    = tc & 5'h1F;
    endtask

    task automatic queue_samples(int unsigned n);
        for (int unsigned i = 0; i < n; i++)
            sample_queue.push_back(pick_sample());
        items_sent += n;
    endtask

    initial
    begin
        int unsigned wl;
        int unsigned tc;
        int unsigned eff;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_idx      = '0;
        cfg_data     = '0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        out_ch.ready = 1'b0;
        hist_ptr     = 0;
        hist_fill    = 0;
        win_len_q    = 3;
        trim_q       = 1;
        error_count  = 0;
        items_sent   = 0;
        no_idle      = 1'b0;
        cycle_count  = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Reset configuration: the first two samples are not ready, then extremes
        // and duplicates go through the three-sample window.
        seed_vals = '{0, SMP_MAX, 0, SMP_MAX, SMP_MAX, 7, 7, 7, 1 << 16, 'h0AAAA,
                      'h15555, 0, 0, SMP_MAX, 5};
        foreach (seed_vals[k])
            sample_queue.push_back(SMP_BITS'(seed_vals[k]));
        items_sent = 15;

        // Extreme settings: oversize window, zero and too-large trims, short windows.
        set_window(4, 0);    queue_samples(4);
        set_window(127, 0);  queue_samples(70);
        set_window(64, 31);  queue_samples(2);
        set_window(65, 32);  queue_samples(2);
        set_window(0, 0);    queue_samples(2);
        set_window(2, 1);    queue_samples(2);
        set_window(3, 31);   queue_samples(2);

        while (items_sent < ITEM_GOAL)
        begin
            case ($urandom_range(0, 9))
                0: wl = $urandom_range(0, 1) ? $urandom_range(0, 2) : $urandom_range(65, 127);
                1: wl = $urandom_range(33, 64);
                default: wl = $urandom_range(3, 16);
            endcase
            eff = (wl > WIN_MAX) ? WIN_MAX : wl;
            case ($urandom_range(0, 7))
                0: tc = 0;
                1: tc = 31;
                2: tc = $urandom_range(0, 31);
                default: tc = (eff > 2) ? $urandom_range(0, (eff - 1) / 2) : 0;
            endcase
            set_window(wl, tc);
            no_idle = ($urandom_range(0, 4) == 0);
            if (eff > 32 && 2 * tc < eff)
                queue_samples($urandom_range(2, 5));
            else
                queue_samples($urandom_range(15, 50));
        end

        wait_drained();
        repeat (200) @(posedge clk);
        if (error_count == 0)
            $display("PASS sliding_window_trimmed_mean");
        else
            $display("FAIL sliding_window_trimmed_mean");
        $finish;
    end
endmodule
